[src/edpd_pkg.sv]
// shared types and constants for the ed25519 point decompression block
// field element type, curve constants, unit opcodes and state encodings
package edpd_pkg;

    typedef logic [254:0] t_fe;

    localparam t_fe P_MOD   = 255'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;
    localparam t_fe D_CONST = 255'h52036cee2b6ffe738cc740797779e89800700a4d4141d8ab75eb4dca135978a3;
    localparam t_fe I_CONST = 255'h2b8324804fc1df0b2b4d00993dfbd7a72f431806ad2fe478c4ee1b274a0ea0b0;
    localparam t_fe ONE_FE  = 255'd1;

    // exponent (p-5)/8 = 2^252-3: bits 251..2 set, bit 1 clear, bit 0 set
    localparam logic [7:0] EXP_TOP = 8'd251;

    typedef enum logic [1:0] {
        FU_MUL,
        FU_ADD,
        FU_SUB
    } t_fu_op;

    typedef struct packed {
        logic   start;
        t_fu_op op;
    } t_fu_req;

    typedef struct packed {
        logic valid;
        logic fail;
        t_fe  x;
        t_fe  y;
        t_fe  t;
    } t_dec_res;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL,
        FS_RED,
        FS_FOLD,
        FS_FRZ,
        FS_ADD,
        FS_SUB,
        FS_FIX
    } t_fu_state;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_Y2,
        S_U,
        S_V,
        S_V1,
        S_B,
        S_SQ,
        S_ML,
        S_X,
        S_W1,
        S_W2,
        S_CMP,
        S_NU,
        S_CMP2,
        S_XI,
        S_ZCHK,
        S_NX,
        S_T,
        S_DONE
    } t_seq_state;

endpackage

[src/edpd_fu.sv]
// field arithmetic unit mod 2^255-19: multiply, add, subtract
// one 32x32 multiply-accumulate per cycle; uses edpd_pkg
module edpd_fu (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  edpd_pkg::t_fu_req i_req,
    input  edpd_pkg::t_fe    i_a,
    input  edpd_pkg::t_fe    i_b,
    output logic             o_done,
    output edpd_pkg::t_fe    o_res
);
    import edpd_pkg::*;

    t_fu_state   r_state;
    t_fu_state   n_state;
    logic [255:0] r_opa;
    logic [255:0] r_opb;
    logic [31:0] r_w [16];
    logic [2:0]  r_i;
    logic [2:0]  r_j;
    logic [31:0] r_cy;
    logic [255:0] r_r;
    logic [39:0] r_c;
    logic        r_pass;
    logic        r_done;

    logic [3:0]  ij;
    logic [31:0] al;
    logic [31:0] bl;
    logic [63:0] prod;
    logic [39:0] red;
    logic [256:0] fsum;
    logic [256:0] frz;
    logic [256:0] diff;

    assign ij   = {1'b0, r_i} + {1'b0, r_j};
    assign al   = r_opa[32*r_i +: 32];
    assign bl   = r_opb[32*r_j +: 32];
    assign prod = al * bl + {32'd0, r_w[ij]} + {32'd0, r_cy};
    assign red  = r_c + {8'd0, r_w[0]} + {8'd0, r_w[8]} * 40'd38;
    assign fsum = {1'b0, r_r} + {211'd0, r_c[39:0] * 46'd38};
    assign frz  = {1'b0, r_r} - {2'b00, P_MOD};
    assign diff = {1'b0, r_opa} - {1'b0, r_opb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state != FS_IDLE) && (n_state == FS_IDLE);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        FU_MUL:  n_state = FS_MUL;
                        FU_ADD:  n_state = FS_ADD;
                        FU_SUB:  n_state = FS_SUB;
                        default: n_state = FS_IDLE;
                    endcase
                end
            end
            FS_MUL:  if (r_i == 3'd7 && r_j == 3'd7) n_state = FS_RED;
            FS_RED:  if (r_i == 3'd7) n_state = FS_FOLD;
            FS_FOLD: if (r_pass) n_state = FS_FRZ;
            FS_FRZ:  if (r_pass) n_state = FS_IDLE;
            FS_ADD:  n_state = FS_FRZ;
            FS_SUB:  n_state = FS_FIX;
            FS_FIX:  n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            FS_IDLE: begin
                if (i_req.start) begin
                    r_opa <= {1'b0, i_a};
                    r_opb <= {1'b0, i_b};
                    for (int k = 0; k < 16; k++) r_w[k] <= '0;
                    r_i    <= '0;
                    r_j    <= '0;
                    r_cy   <= '0;
                    r_c    <= '0;
                    r_pass <= 1'b0;
                end
            end
            FS_MUL: begin
                r_w[ij] <= prod[31:0];
                if (r_j == 3'd7) begin
                    r_w[{1'b0, r_i} + 4'd8] <= prod[63:32];
                    r_cy <= '0;
                    r_i  <= r_i + 3'd1;
                end else begin
                    r_cy <= prod[63:32];
                end
                r_j <= r_j + 3'd1;
            end
            FS_RED: begin
                // fold high half by 2^256 = 38 mod p, one limb per cycle
                r_r <= {red[31:0], r_r[255:32]};
                r_c <= {32'd0, red[39:32]};
                for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
                r_w[15] <= '0;
                r_i     <= r_i + 3'd1;
                r_pass  <= 1'b0;
            end
            FS_FOLD: begin
                r_r    <= fsum[255:0];
                r_c    <= {39'd0, fsum[256]};
                r_pass <= ~r_pass;
            end
            FS_FRZ: begin
                if (!frz[256]) r_r <= frz[255:0];
                r_pass <= ~r_pass;
            end
            FS_ADD: begin
                r_r    <= r_opa + r_opb;
                r_pass <= 1'b0;
            end
            FS_SUB: begin
                r_r <= diff[255:0];
                r_c <= {39'd0, diff[256]};
            end
            FS_FIX: begin
                if (r_c[0]) r_r <= r_r + {1'b0, P_MOD};
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_r[254:0];

endmodule

[src/edpd_seq.sv]
// decoding sequencer: holds the working field elements and drives edpd_fu
// step by step through the square-root candidate and its checks; uses edpd_pkg
module edpd_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [255:0]       i_enc,
    output logic               o_idle,
    output edpd_pkg::t_fu_req  o_fu_req,
    output edpd_pkg::t_fe      o_fu_a,
    output edpd_pkg::t_fe      o_fu_b,
    input  logic               i_fu_done,
    input  edpd_pkg::t_fe      i_fu_res,
    input  logic               i_out_free,
    output edpd_pkg::t_dec_res o_res
);
    import edpd_pkg::*;

    t_seq_state r_state;
    t_seq_state n_state;
    t_fe        r_y;
    t_fe        r_u;
    t_fe        r_v;
    t_fe        r_b;
    t_fe        r_acc;
    t_fe        r_x;
    t_fe        r_w;
    logic       r_sign;
    logic       r_fail;
    logic [7:0] r_bit;
    logic       r_busy;
    logic       is_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_fu_done) r_busy <= 1'b0;
            else if (o_fu_req.start) r_busy <= 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        is_op       = 1'b1;
        o_fu_req.op = FU_MUL;
        o_fu_a      = r_acc;
        o_fu_b      = r_acc;
        case (r_state)
            S_IDLE: begin
                is_op = 1'b0;
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                is_op = 1'b0;
                n_state = (r_y >= P_MOD) ? S_DONE : S_Y2;
            end
            S_Y2: begin
                o_fu_a = r_y;
                o_fu_b = r_y;
                if (i_fu_done) n_state = S_U;
            end
            S_U: begin
                o_fu_req.op = FU_SUB;
                o_fu_a      = r_w;
                o_fu_b      = ONE_FE;
                if (i_fu_done) n_state = S_V;
            end
            S_V: begin
                o_fu_a = r_w;
                o_fu_b = D_CONST;
                if (i_fu_done) n_state = S_V1;
            end
            S_V1: begin
                o_fu_req.op = FU_ADD;
                o_fu_a      = r_v;
                o_fu_b      = ONE_FE;
                if (i_fu_done) n_state = S_B;
            end
            S_B: begin
                o_fu_a = r_u;
                o_fu_b = r_v;
                if (i_fu_done) n_state = S_SQ;
            end
            S_SQ: begin
                if (i_fu_done) n_state = (r_bit == 8'd1) ? S_SQ : S_ML;
            end
            S_ML: begin
                o_fu_b = r_b;
                if (i_fu_done) n_state = (r_bit == 8'd0) ? S_X : S_SQ;
            end
            S_X: begin
                o_fu_a = r_u;
                if (i_fu_done) n_state = S_W1;
            end
            S_W1: begin
                o_fu_a = r_x;
                o_fu_b = r_x;
                if (i_fu_done) n_state = S_W2;
            end
            S_W2: begin
                o_fu_a = r_v;
                o_fu_b = r_w;
                if (i_fu_done) n_state = S_CMP;
            end
            S_CMP: begin
                is_op = 1'b0;
                n_state = (r_w == r_u) ? S_ZCHK : S_NU;
            end
            S_NU: begin
                o_fu_req.op = FU_SUB;
                o_fu_a      = '0;
                o_fu_b      = r_u;
                if (i_fu_done) n_state = S_CMP2;
            end
            S_CMP2: begin
                is_op = 1'b0;
                n_state = (r_w == r_b) ? S_XI : S_DONE;
            end
            S_XI: begin
                o_fu_a = r_x;
                o_fu_b = I_CONST;
                if (i_fu_done) n_state = S_ZCHK;
            end
            S_ZCHK: begin
                is_op = 1'b0;
                if (r_sign && r_x == '0) n_state = S_DONE;
                else if (r_x[0] != r_sign) n_state = S_NX;
                else n_state = S_T;
            end
            S_NX: begin
                o_fu_req.op = FU_SUB;
                o_fu_a      = '0;
                o_fu_b      = r_x;
                if (i_fu_done) n_state = S_T;
            end
            S_T: begin
                o_fu_a = r_x;
                o_fu_b = r_y;
                if (i_fu_done) n_state = S_DONE;
            end
            S_DONE: begin
                is_op = 1'b0;
                if (i_out_free) n_state = S_IDLE;
            end
            default: begin
                is_op   = 1'b0;
                n_state = S_IDLE;
            end
        endcase
        o_fu_req.start = is_op && !r_busy && !i_fu_done;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_y    <= i_enc[254:0];
                    r_sign <= i_enc[255];
                    r_fail <= 1'b0;
                end
            end
            S_CHECK: if (r_y >= P_MOD) r_fail <= 1'b1;
            S_Y2:    if (i_fu_done) r_w <= i_fu_res;
            S_U:     if (i_fu_done) r_u <= i_fu_res;
            S_V:     if (i_fu_done) r_v <= i_fu_res;
            S_V1:    if (i_fu_done) r_v <= i_fu_res;
            S_B: begin
                if (i_fu_done) begin
                    r_b   <= i_fu_res;
                    r_acc <= ONE_FE;
                    r_bit <= EXP_TOP;
                end
            end
            S_SQ: begin
                if (i_fu_done) begin
                    r_acc <= i_fu_res;
                    if (r_bit == 8'd1) r_bit <= 8'd0;
                end
            end
            S_ML: begin
                if (i_fu_done) begin
                    r_acc <= i_fu_res;
                    if (r_bit != 8'd0) r_bit <= r_bit - 8'd1;
                end
            end
            S_X:     if (i_fu_done) r_x <= i_fu_res;
            S_W1:    if (i_fu_done) r_w <= i_fu_res;
            S_W2:    if (i_fu_done) r_w <= i_fu_res;
            S_NU:    if (i_fu_done) r_b <= i_fu_res;
            S_CMP2:  if (r_w != r_b) r_fail <= 1'b1;
            S_XI:    if (i_fu_done) r_x <= i_fu_res;
            S_ZCHK:  if (r_sign && r_x == '0) r_fail <= 1'b1;
            S_NX:    if (i_fu_done) r_x <= i_fu_res;
            S_T:     if (i_fu_done) r_b <= i_fu_res;
            default: ;
        endcase
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.fail  = r_fail;
    assign o_res.x     = r_x;
    assign o_res.y     = r_y;
    assign o_res.t     = r_b;

endmodule

[src/ed25519_point_decompress.sv]
// top level of the ed25519 point decompression block
// instantiates edpd_seq and edpd_fu, holds the result buffer; uses edpd_pkg
//
// input stream: one item is a 256-bit point encoding (y in bits 254..0,
// sign of x in bit 255), taken when s_axis_tvalid and s_axis_tready are high.
// output stream: four items per input, word_index 0..3, each carrying the
// matching 64-bit words of x, y, z and t = x*y; tlast marks the fourth item,
// tuser is set when the encoding is invalid (then x, y, z and t are zero).
// decode time is set by the field unit, which forms each 255-bit product with
// one 32x32 multiply-accumulate per cycle; exponentiation needs 503 products.
// s_axis_tready is high only while the sequencer is idle; one item is decoded
// at a time. results wait in an output buffer, so the next item is accepted
// while earlier results drain; a stalled receiver holds the buffer and
// eventually holds back the sequencer at its final step.
// reset (synchronous, active low) drops any item in flight and empties the
// output buffer.
module ed25519_point_decompress (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // enc_word0, enc_word1, enc_word2, enc_word3
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [263:0] m_axis_tdata,  // word_index, x_word, y_word, z_word, t_word, pad
    output logic         m_axis_tuser,  // status
    output logic         m_axis_tlast
);
    import edpd_pkg::*;

    t_fu_req  fu_req;
    t_fe      fu_a;
    t_fe      fu_b;
    logic     fu_done;
    t_fe      fu_res;
    t_dec_res dec_res;
    logic     seq_idle;
    logic     out_free;

    logic         r_ovalid;
    logic [1:0]   r_idx;
    logic         r_fail;
    logic [255:0] r_x;
    logic [255:0] r_y;
    logic [255:0] r_t;
    logic [63:0]  x_word;
    logic [63:0]  y_word;
    logic [63:0]  z_word;
    logic [63:0]  t_word;

    edpd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_enc      (s_axis_tdata),
        .o_idle     (seq_idle),
        .o_fu_req   (fu_req),
        .o_fu_a     (fu_a),
        .o_fu_b     (fu_b),
        .i_fu_done  (fu_done),
        .i_fu_res   (fu_res),
        .i_out_free (out_free),
        .o_res      (dec_res)
    );

    edpd_fu u_fu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fu_req),
        .i_a     (fu_a),
        .i_b     (fu_b),
        .o_done  (fu_done),
        .o_res   (fu_res)
    );

    assign out_free      = !r_ovalid;
    assign s_axis_tready = seq_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else if (dec_res.valid && !r_ovalid) begin
            r_ovalid <= 1'b1;
            r_idx    <= '0;
        end else if (r_ovalid && m_axis_tready) begin
            if (r_idx == 2'd3) r_ovalid <= 1'b0;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_res.valid && !r_ovalid) begin
            r_fail <= dec_res.fail;
            r_x    <= dec_res.fail ? '0 : {1'b0, dec_res.x};
            r_y    <= dec_res.fail ? '0 : {1'b0, dec_res.y};
            r_t    <= dec_res.fail ? '0 : {1'b0, dec_res.t};
        end
    end

    assign x_word = r_x[64*r_idx +: 64];
    assign y_word = r_y[64*r_idx +: 64];
    assign t_word = r_t[64*r_idx +: 64];
    assign z_word = (!r_fail && r_idx == 2'd0) ? 64'd1 : 64'd0;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, t_word, z_word, y_word, x_word, r_idx};
    assign m_axis_tuser  = r_fail;
    assign m_axis_tlast  = (r_idx == 2'd3);

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[257:2] == '0)
        else $error("failed decode carries nonzero coordinates");

    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while decoding");

    a_z_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[193:130] == '0)
        else $error("z word nonzero above word 0");

endmodule

[sim/ed25519_point_decompress_tb.sv]
// testbench for ed25519_point_decompress: streams point encodings in, checks x, y, z, t words
// holds its own field arithmetic decoder for prediction; depends on edpd_pkg and the rtl
module ed25519_point_decompress_tb;
    import edpd_pkg::*;

    localparam int IDLE_LIMIT = 1000000;
    localparam int LONG_HOLD  = 150000;

    typedef struct {
        logic [255:0] enc;
        bit           wait_drain;
    } t_enc_item;

    typedef struct {
        logic        status;
        logic [1:0]  idx;
        logic [63:0] xw, yw, zw, tw;
        logic        last;
    } t_coord_beat;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;  // enc_word0, enc_word1, enc_word2, enc_word3
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [263:0] m_axis_tdata;  // word_index, x_word, y_word, z_word, t_word, pad
    logic         m_axis_tuser;  // status
    logic         m_axis_tlast;

    t_enc_item   enc_pending[$];
    t_coord_beat coord_expected[$];
    int          n_errors, n_decoded, n_rejected, n_beats, idle_cycles;
    int          burst_left, gap_left, hold_left, mode_cnt;
    bit          hold_done, ready_free;

    ed25519_point_decompress dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_fe fe_mul(t_fe a, t_fe b);
        logic [511:0] prod;
        prod = {257'd0, a} * {257'd0, b};
        return t_fe'(prod % {257'd0, P_MOD});
    endfunction

    function automatic t_fe fe_add(t_fe a, t_fe b);
        logic [255:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, P_MOD}) s = s - {1'b0, P_MOD};
        return s[254:0];
    endfunction

    function automatic t_fe fe_neg(t_fe a);
        return (a == '0) ? '0 : P_MOD - a;
    endfunction

    // decode one encoding and queue its four coordinate words
    function automatic void predict_point(logic [255:0] enc);
        t_fe         y, y2, u, v, acc, x, vx2, t, z;
        logic        sgn, ok;
        t_coord_beat b;
        y   = enc[254:0];
        sgn = enc[255];
        ok  = 1'b0;
        x   = '0;
        if (y < P_MOD) begin
            y2  = fe_mul(y, y);
            u   = fe_add(y2, fe_neg(ONE_FE));
            v   = fe_add(fe_mul(y2, D_CONST), ONE_FE);
            acc = ONE_FE;
            // raise u*v to 2^252-3
            for (int i = 251; i >= 0; i--) begin
                acc = fe_mul(acc, acc);
                if (i != 1) acc = fe_mul(acc, fe_mul(u, v));
            end
            x   = fe_mul(u, acc);
            vx2 = fe_mul(v, fe_mul(x, x));
            ok  = 1'b1;
            if (vx2 != u) begin
                if (vx2 == fe_neg(u)) x = fe_mul(x, I_CONST);
                else ok = 1'b0;
            end
            if (ok && sgn && x == '0) ok = 1'b0;
            if (ok && x[0] != sgn) x = fe_neg(x);
        end
        if (ok) begin
            t = fe_mul(x, y);
            z = ONE_FE;
            n_decoded++;
        end else begin
            x = '0; y = '0; t = '0; z = '0;
            n_rejected++;
        end
        for (int k = 0; k < 4; k++) begin
            b.status = !ok;
            b.idx    = 2'(k);
            b.xw     = 64'({1'b0, x} >> (64 * k));
            b.yw     = 64'({1'b0, y} >> (64 * k));
            b.zw     = 64'({1'b0, z} >> (64 * k));
            b.tw     = 64'({1'b0, t} >> (64 * k));
            b.last   = (k == 3);
            coord_expected.push_back(b);
        end
    endfunction

    function automatic void add_enc(logic [255:0] enc, bit wait_drain = 0);
        t_enc_item it;
        it.enc        = enc;
        it.wait_drain = wait_drain;
        enc_pending.push_back(it);
    endfunction

    // sender: bursts of items with random gaps
    always @(posedge i_clk) begin
        logic         nxt_valid;
        logic [255:0] nxt_data;
        t_enc_item    nxt_item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            nxt_valid = s_axis_tvalid;
            nxt_data  = s_axis_tdata;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_point(s_axis_tdata);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (enc_pending.size() > 0 &&
                             !(enc_pending[0].wait_drain && coord_expected.size() > 0)) begin
                    nxt_item  = enc_pending.pop_front();
                    nxt_data  = nxt_item.enc;
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
            end
            s_axis_tvalid <= nxt_valid;
            s_axis_tdata  <= nxt_data;
        end
    end

    // receiver: random stalls alternating with free-running stretches, one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 0;
            mode_cnt      <= 0;
            ready_free    <= 0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && n_beats >= 20) begin
            hold_done     <= 1;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            mode_cnt <= mode_cnt + 1;
            if (mode_cnt % 64 == 63) ready_free <= !ready_free;
            m_axis_tready <= ready_free || ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_coord_beat e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_beats <= n_beats + 1;
            if (coord_expected.size() == 0) begin
                $error("result item with nothing expected");
                n_errors++;
            end else begin
                e = coord_expected.pop_front();
                if (m_axis_tuser !== e.status) begin
                    $error("status exp %0h got %0h", e.status, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tdata[1:0] !== e.idx) begin
                    $error("word_index exp %0h got %0h", e.idx, m_axis_tdata[1:0]);
                    n_errors++;
                end
                if (m_axis_tdata[65:2] !== e.xw) begin
                    $error("x_word exp %h got %h", e.xw, m_axis_tdata[65:2]);
                    n_errors++;
                end
                if (m_axis_tdata[129:66] !== e.yw) begin
                    $error("y_word exp %h got %h", e.yw, m_axis_tdata[129:66]);
                    n_errors++;
                end
                if (m_axis_tdata[193:130] !== e.zw) begin
                    $error("z_word exp %h got %h", e.zw, m_axis_tdata[193:130]);
                    n_errors++;
                end
                if (m_axis_tdata[257:194] !== e.tw) begin
                    $error("t_word exp %h got %h", e.tw, m_axis_tdata[257:194]);
                    n_errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last exp %0h got %0h", e.last, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", coord_expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [255:0] r;
        logic [254:0] base_y;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        n_errors    = 0;
        n_decoded   = 0;
        n_rejected  = 0;
        n_beats     = 0;
        idle_cycles = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        base_y = 255'h6666666666666666666666666666666666666666666666666666666666666658;

        // y = 0 gives x = sqrt(-1); y = +-1 gives x = 0, invalid with the sign set
        add_enc({1'b0, 255'd0});
        add_enc({1'b1, 255'd0});
        add_enc({1'b0, 255'd1});
        add_enc({1'b1, 255'd1});
        add_enc({1'b0, P_MOD - 255'd1});
        add_enc({1'b1, P_MOD - 255'd1});
        add_enc({1'b0, base_y});
        add_enc({1'b1, base_y});
        add_enc({1'b0, 255'd2});
        add_enc({1'b1, 255'd3});
        // non-canonical y, then d and sqrt(-1) as y
        add_enc({1'b0, P_MOD});
        add_enc({1'b1, P_MOD + 255'd1});
        add_enc({1'b0, {255{1'b1}}});
        add_enc({1'b1, {255{1'b1}}});
        add_enc({1'b0, D_CONST});
        add_enc({1'b1, I_CONST}, 1);
        for (int n = 0; n < 134; n++) begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            if ($urandom_range(0, 9) == 0) r[254:0] = P_MOD + 255'($urandom_range(0, 18));
            add_enc(r, n == 70);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (enc_pending.size() == 0 && !s_axis_tvalid);
        wait (coord_expected.size() == 0);
        repeat (200) @(posedge i_clk);

        $display("decoded %0d points, rejected %0d encodings, %0d result items checked",
                 n_decoded, n_rejected, n_beats);
        $display("covered sqrt(-1) correction, zero x, non-canonical y and long output stall");
        if (n_errors == 0 && coord_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
